// ----- hw/rtl/ifp_pkg.sv -----
`default_nettype none
package ifp_pkg;

  localparam int unsigned KW_COUNT   = 6;
  localparam int unsigned KW_MAX_LEN = 9;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_OPEN    = 2'd1,
    ST_NOT_CLOSED = 2'd2
  } ifp_status_e;

  typedef enum logic [2:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_SPACE,
    CLS_NUL,
    CLS_OTHER
  } ifp_class_e;

  typedef struct packed {
    ifp_class_e cls;
    logic [7:0] ch;
    logic       last;
  } ifp_item_t;

  localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd9, 4'd8, 4'd6, 4'd8, 4'd5, 4'd7
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{CH_BSL, "a", "n", "s", "w", "e", "r", "e", "d"},
    '{CH_BSL, "d", "e", "l", "e", "t", "e", "d", 8'h00},
    '{CH_BSL, "d", "r", "a", "f", "t", 8'h00, 8'h00, 8'h00},
    '{CH_BSL, "f", "l", "a", "g", "g", "e", "d", 8'h00},
    '{CH_BSL, "s", "e", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00},
    '{CH_BSL, "r", "e", "c", "e", "n", "t", 8'h00, 8'h00}
  };

endpackage
`default_nettype wire

// ----- hw/rtl/imap_flag_list_parser.sv -----
// IMAP flag list parser.
// Slave stream s_axis carries the list text one byte per transfer; tlast
// marks the final byte of the buffer. Master stream m_axis carries one
// result per finished list: tdata holds the six flag bits (answered,
// deleted, draft, flagged, seen, recent from bit 0 up), tuser the status
// (0 ok, 1 no opening parenthesis, 2 list not closed; flags zero on error).
// A byte that ends a list or raises an error gives exactly one result;
// all other bytes give none.
// Throughput is one byte per cycle while the result register is not held
// by m_axis_tready: the classify stage, the four-entry queue and the parser each handle one byte a cycle.
// A byte is registered in the classify stage, written into the queue and
// parsed from the queue head; the result register then drives m_axis_tvalid.
// When m_axis_tready is low the result register holds and the parser
// stalls on the next byte; the queue and the classify stage hold up to
// five bytes, the stalled one included, before s_axis_tready falls.
// Reset (rst_ni low) empties the queue, drops any pending result and
// leaves the parser waiting for an opening parenthesis.
`default_nettype none
module imap_flag_list_parser
  import ifp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [5:0] flag_bits, [7:6] zero
  output logic [1:0]      m_axis_tuser    // [1:0] parse_status
);

  logic      fr_valid, fr_ready, q_valid, q_ready;
  ifp_item_t fr_item, q_item;
  logic [5:0] flag_bits;

  ifp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  ifp_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  ifp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_item),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .flag_bits_o    (flag_bits),
    .parse_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, flag_bits};

endmodule
`default_nettype wire

// ----- hw/rtl/ifp_front.sv -----
`default_nettype none
module ifp_front
  import ifp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic      in_last_i,
  output logic           item_valid_o,
  input  wire logic      item_ready_i,
  output ifp_item_t      item_o
);

  logic      valid_q, valid_d;
  ifp_item_t item_q, item_d;
  logic      take;

  assign in_ready_o = !valid_q || item_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    item_d = item_q;
    valid_d = valid_q;
    if (item_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = 1'b1;
      item_d.last = in_last_i;
      item_d.ch = in_byte_i;
      if (in_byte_i >= "A" && in_byte_i <= "Z") begin
        item_d.ch = in_byte_i + 8'd32;
      end
      case (in_byte_i)
        CH_OPEN:  item_d.cls = CLS_OPEN;
        CH_CLOSE: item_d.cls = CLS_CLOSE;
        CH_SPACE: item_d.cls = CLS_SPACE;
        CH_NUL:   item_d.cls = CLS_NUL;
        default:  item_d.cls = CLS_OTHER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule
`default_nettype wire

// ----- hw/rtl/ifp_fifo.sv -----
`default_nettype none
module ifp_fifo
  import ifp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  output logic           push_ready_o,
  input  wire ifp_item_t push_item_i,
  output logic           pop_valid_o,
  input  wire logic      pop_ready_i,
  output ifp_item_t      pop_item_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  ifp_item_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_FULL;
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? PTR_W'(wr_q + 1'b1) : wr_q;
    rd_d  = pop ? PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_FULL)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

endmodule
`default_nettype wire

// ----- hw/rtl/ifp_back.sv -----
`default_nettype none
module ifp_back
  import ifp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  output logic            item_ready_o,
  input  wire ifp_item_t  item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [5:0]      flag_bits_o,
  output logic [1:0]      parse_status_o
);

  logic              in_list_q, in_list_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [5:0]        alive_q, alive_d;
  logic [5:0]        acc_q, acc_d;
  logic              out_valid_q, out_valid_d;
  logic [5:0]        flags_q, flags_d;
  ifp_status_e       status_q, status_d;
  logic              pop, emit;
  logic [5:0]        match, pick;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign pop = item_valid_i && item_ready_o;

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      match[k] = (pos_q < KW_LEN[k]) &&
                 (KW_TEXT[k][pos_q] == item_i.ch);
    end
    pick = (pos_q != '0) ? (alive_q & (~alive_q + 6'd1)) : 6'd0;
  end

  always_comb begin
    in_list_d   = in_list_q;
    pos_d       = pos_q;
    alive_d     = alive_q;
    acc_d       = acc_q;
    flags_d     = flags_q;
    status_d    = status_q;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop) begin
      if (!in_list_q) begin
        if (item_i.cls != CLS_OPEN) begin
          emit = 1'b1;
          flags_d = 6'd0;
          status_d = ST_NO_OPEN;
        end else if (item_i.last) begin
          emit = 1'b1;
          flags_d = 6'd0;
          status_d = ST_NOT_CLOSED;
        end else begin
          in_list_d = 1'b1;
          acc_d = 6'd0;
          pos_d = '0;
          alive_d = '1;
        end
      end else if (item_i.cls == CLS_CLOSE) begin
        emit = 1'b1;
        flags_d = acc_q | pick;
        status_d = ST_OK;
      end else if (item_i.cls == CLS_NUL || item_i.last) begin
        emit = 1'b1;
        flags_d = 6'd0;
        status_d = ST_NOT_CLOSED;
      end else if (item_i.cls == CLS_SPACE) begin
        acc_d = acc_q | pick;
        pos_d = '0;
        alive_d = '1;
      end else begin
        alive_d = alive_q & match;
        if (pos_q != POS_MAX) begin
          pos_d = pos_q + 1'b1;
        end
      end
      if (emit) begin
        out_valid_d = 1'b1;
        in_list_d = 1'b0;
        acc_d = 6'd0;
        pos_d = '0;
        alive_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_list_q   <= 1'b0;
      pos_q       <= '0;
      alive_q     <= '1;
      acc_q       <= 6'd0;
      out_valid_q <= 1'b0;
    end else begin
      in_list_q   <= in_list_d;
      pos_q       <= pos_d;
      alive_q     <= alive_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q  <= flags_d;
    status_q <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign flag_bits_o    = flags_q;
  assign parse_status_o = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && status_q != ST_OK) |-> (flags_q == 6'd0))
    else $error("error result carries flags");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pop && emit) |=> (!in_list_q && acc_q == 6'd0))
    else $error("parser did not rearm after result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (pos_q == '0) |-> (alive_q == 6'h3F))
    else $error("empty token with pruned keywords");

endmodule
`default_nettype wire
